### rtl/lkvc_pkg.sv
// Package: shared types, codes and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam int ENTRIES_DEF        = 64;
  localparam int KEY_BITS_DEF       = 64;
  localparam int VALUE_BITS_DEF     = 64;
  localparam int ITERATOR_BYTES_DEF = 8;

  localparam int OCC_W = 31;
  localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_UPDATE = 3'd1,
    CMD_ADMIT  = 3'd2,
    CMD_VICTIM = 3'd3,
    CMD_EVICT  = 3'd4,
    CMD_EXISTS = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_PRESENT = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOK,
    FSM_EXEC
  } fsm_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the input word
    logic look;      // register match/free/victim search results
    logic exec;      // apply the command and latch the result
  } dp_cmd_t;

endpackage

### rtl/lru_key_value_cache_top.sv
// Top level: LRU key-value cache with stream command and result channels.
//  channel | ports         | tdata fields (low bit up)
//  command | in_t*         | command, key, key_length, write_value, value_size
//  result  | out_t*        | status, hit, read_value, victim_key, occupancy_bytes
// Each command passes through three steps: accept, parallel key search, execute.
// The result word is valid the cycle after execute and sits in its own register,
// so the next command is accepted and searched while it waits.
// An untaken result stalls only the execute step of the following command.
// rst_n synchronous, clears valid bits, entry count, occupancy and the result valid.
module lru_key_value_cache_top #(
  parameter int ENTRIES        = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS       = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS     = lkvc_pkg::VALUE_BITS_DEF,
  parameter int ITERATOR_BYTES = lkvc_pkg::ITERATOR_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [175:0] in_tdata,   // command[2:0], key[66:3], key_length[82:67],
                                   // write_value[146:83], value_size[170:147]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata   // status[2:0], hit[3], read_value[67:4],
                                   // victim_key[131:68], occupancy_bytes[162:132]
);

  lkvc_pkg::dp_cmd_t cmd;
  logic [2:0]  st;
  logic        hit;
  logic [63:0] rv, vk;
  logic [30:0] occ;

  lkvc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd
  );

  lkvc_datapath #(
    .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
    .ITERATOR_BYTES(ITERATOR_BYTES)
  ) u_dp (
    .clk, .rst_n, .cmd,
    .in_command    (in_tdata[2:0]),
    .in_key        (in_tdata[66:3]),
    .in_key_length (in_tdata[82:67]),
    .in_write_value(in_tdata[146:83]),
    .in_value_size (in_tdata[170:147]),
    .res_status    (st),
    .res_hit       (hit),
    .res_read_value(rv),
    .res_victim_key(vk),
    .res_occupancy (occ)
  );

  assign out_tdata = {5'd0, occ, vk, rv, hit, st};

endmodule

### rtl/lkvc_datapath.sv
// Datapath: entry storage, parallel key compare, recency ranks, occupancy.
module lkvc_datapath #(
  parameter int ENTRIES        = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS       = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS     = lkvc_pkg::VALUE_BITS_DEF,
  parameter int ITERATOR_BYTES = lkvc_pkg::ITERATOR_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lkvc_pkg::dp_cmd_t      cmd,
  input  logic [2:0]             in_command,
  input  logic [63:0]            in_key,
  input  logic [15:0]            in_key_length,
  input  logic [63:0]            in_write_value,
  input  logic [23:0]            in_value_size,
  output logic [2:0]             res_status,
  output logic                   res_hit,
  output logic [63:0]            res_read_value,
  output logic [63:0]            res_victim_key,
  output logic [30:0]            res_occupancy
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // Captured command word
  logic [2:0]            c_cmd_r;
  logic [KEY_BITS-1:0]   c_key_r;
  logic [15:0]           c_klen_r;
  logic [VALUE_BITS-1:0] c_val_r;
  logic [23:0]           c_vsize_r;

  // Per-entry state
  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] val_r   [ENTRIES];
  logic [15:0]           klen_r  [ENTRIES];
  logic [23:0]           vsize_r [ENTRIES];
  logic [IW-1:0]         rank_r  [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [CW-1:0]         count_r;
  logic [30:0]           used_r;

  // Search results registered between look and exec
  logic                  found_r, free_ok_r, vic_ok_r;
  logic [IW-1:0]         slot_r, free_r, vic_r;
  logic [15:0]           old_klen_r;
  logic [23:0]           old_vsize_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_cmd_r   <= in_command;
      c_key_r   <= in_key[KEY_BITS-1:0];
      c_klen_r  <= in_key_length;
      c_val_r   <= in_write_value[VALUE_BITS-1:0];
      c_vsize_r <= in_value_size;
    end
  end

  // Parallel compare and priority searches
  logic [ENTRIES-1:0] match_v, vic_v;
  logic               f_found, f_free, f_vic;
  logic [IW-1:0]      f_slot, f_freei, f_vici;
  logic [CW-1:0]      last_rank;

  assign last_rank = count_r - CW'(1);

  always_comb begin
    f_found = 1'b0; f_free = 1'b0; f_vic = 1'b0;
    f_slot = '0; f_freei = '0; f_vici = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_v[i] = valid_r[i] && (key_r[i] == c_key_r);
      vic_v[i]   = valid_r[i] && (CW'(rank_r[i]) == last_rank);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_v[i]) begin f_found = 1'b1; f_slot = IW'(i); end
      if (!valid_r[i]) begin f_free = 1'b1; f_freei = IW'(i); end
      if (vic_v[i]) begin f_vic = 1'b1; f_vici = IW'(i); end
    end
  end

  // Search results, plus the stored sizes of the matching entry
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      found_r <= f_found; slot_r <= f_slot;
      free_ok_r <= f_free; free_r <= f_freei;
      vic_ok_r <= f_vic && (count_r != '0); vic_r <= f_vici;
      old_klen_r  <= klen_r[f_slot];
      old_vsize_r <= vsize_r[f_slot];
    end
  end

  // Occupancy terms
  logic [IW-1:0] srank;
  logic [33:0]   new_cost, old_cost, adm_cost, evi_cost, sum_u, dif_u;
  logic [30:0]   upd_used;
  assign srank    = rank_r[slot_r];
  assign new_cost = 34'(c_klen_r) + 34'(c_vsize_r);
  assign old_cost = 34'(old_klen_r) + 34'(old_vsize_r);
  assign adm_cost = 34'({c_klen_r, 1'b0}) + 34'(c_vsize_r) + 34'(ITERATOR_BYTES);
  assign evi_cost = 34'({old_klen_r, 1'b0}) + 34'(old_vsize_r)
                  + 34'(ITERATOR_BYTES);
  assign sum_u    = 34'(used_r) + new_cost;
  assign upd_used = (sum_u > 34'(lkvc_pkg::OCC_MAX)) ? lkvc_pkg::OCC_MAX : sum_u[30:0];
  assign dif_u    = 34'(used_r) + adm_cost;

  // Command execution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      used_r  <= '0;
    end else if (cmd.exec) begin
      res_status     <= lkvc_pkg::ST_DONE;
      res_hit        <= 1'b0;
      res_read_value <= '0;
      res_victim_key <= '0;
      res_occupancy  <= used_r;
      unique case (c_cmd_r) inside
        lkvc_pkg::CMD_GET, lkvc_pkg::CMD_UPDATE, lkvc_pkg::CMD_EXISTS: begin
          if (!found_r) begin
            res_status <= lkvc_pkg::ST_ABSENT;
          end else begin
            res_hit <= 1'b1;
            if (c_cmd_r != lkvc_pkg::CMD_EXISTS) begin
              for (int i = 0; i < ENTRIES; i++)
                if (valid_r[i] && rank_r[i] < srank) rank_r[i] <= rank_r[i] + IW'(1);
              rank_r[slot_r] <= '0;
            end
            if (c_cmd_r == lkvc_pkg::CMD_GET)
              res_read_value <= 64'(val_r[slot_r]);
            if (c_cmd_r == lkvc_pkg::CMD_UPDATE) begin
              val_r[slot_r]   <= c_val_r;
              klen_r[slot_r]  <= c_klen_r;
              vsize_r[slot_r] <= c_vsize_r;
              used_r        <= (34'(upd_used) <= old_cost) ? '0
                               : 31'(34'(upd_used) - old_cost);
              res_occupancy <= (34'(upd_used) <= old_cost) ? '0
                               : 31'(34'(upd_used) - old_cost);
            end
          end
        end
        lkvc_pkg::CMD_ADMIT: begin
          if (found_r) begin
            res_status <= lkvc_pkg::ST_PRESENT;
            res_hit    <= 1'b1;
          end else if (!free_ok_r) begin
            res_status <= lkvc_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i]) rank_r[i] <= rank_r[i] + IW'(1);
            key_r[free_r]   <= c_key_r;
            val_r[free_r]   <= c_val_r;
            klen_r[free_r]  <= c_klen_r;
            vsize_r[free_r] <= c_vsize_r;
            rank_r[free_r]  <= '0;
            valid_r[free_r] <= 1'b1;
            count_r         <= count_r + CW'(1);
            used_r        <= (dif_u > 34'(lkvc_pkg::OCC_MAX)) ? lkvc_pkg::OCC_MAX
                             : dif_u[30:0];
            res_occupancy <= (dif_u > 34'(lkvc_pkg::OCC_MAX)) ? lkvc_pkg::OCC_MAX
                             : dif_u[30:0];
          end
        end
        lkvc_pkg::CMD_VICTIM: begin
          if (vic_ok_r) begin
            res_hit        <= 1'b1;
            res_victim_key <= 64'(key_r[vic_r]);
          end else begin
            res_status <= lkvc_pkg::ST_EMPTY;
          end
        end
        lkvc_pkg::CMD_EVICT: begin
          if (!found_r) begin
            res_status <= lkvc_pkg::ST_ABSENT;
          end else begin
            res_hit        <= 1'b1;
            res_read_value <= 64'(val_r[slot_r]);
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i] && rank_r[i] > srank) rank_r[i] <= rank_r[i] - IW'(1);
            valid_r[slot_r] <= 1'b0;
            if (count_r != '0) count_r <= count_r - CW'(1);
            used_r        <= (evi_cost >= 34'(used_r)) ? '0 : 31'(34'(used_r) - evi_cost);
            res_occupancy <= (evi_cost >= 34'(used_r)) ? '0 : 31'(34'(used_r) - evi_cost);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/lkvc_ctrl.sv
// Controller: sequences capture, search and execute, and tracks the result word.
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output lkvc_pkg::dp_cmd_t cmd
);

  lkvc_pkg::fsm_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkvc_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // Execute waits only while an untaken result word occupies the output
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      lkvc_pkg::FSM_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = lkvc_pkg::FSM_LOOK;
      end
      lkvc_pkg::FSM_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = lkvc_pkg::FSM_EXEC;
      end
      lkvc_pkg::FSM_EXEC: begin
        if (!out_valid_r || out_tready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lkvc_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = lkvc_pkg::FSM_IDLE;
    endcase
  end

endmodule
